FILE: hw/rtl/cwab_pkg.sv
// Shared types and constants for the clipped window alpha blit.
// No dependencies; used by every module of the block.
package cwab_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int PIX_W       = 24;
	localparam int ADDR_W      = 24;
	localparam int POS_W       = 13;
	localparam int ALPHA_W     = 8;

	localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_X      = 3'd0,
		REG_WINDOW_Y      = 3'd1,
		REG_WINDOW_WIDTH  = 3'd2,
		REG_WINDOW_HEIGHT = 3'd3,
		REG_BLEND_ALPHA   = 3'd4,
		REG_WINDOW_VIS    = 3'd5,
		REG_SCREEN_WIDTH  = 3'd6,
		REG_SCREEN_HEIGHT = 3'd7
	} reg_idx_t;

	// dims already clamped to 1..MAX_DIM
	typedef struct packed {
		logic signed [CFG_DATA_W-1:0] window_x;
		logic signed [CFG_DATA_W-1:0] window_y;
		logic [CFG_DATA_W-1:0]        window_width;
		logic [CFG_DATA_W-1:0]        window_height;
		logic [ALPHA_W-1:0]           blend_alpha;
		logic                         window_visible;
		logic [CFG_DATA_W-1:0]        screen_width;
		logic [CFG_DATA_W-1:0]        screen_height;
	} cfg_t;

	typedef struct packed {
		logic             we;
		logic             last;
		logic [POS_W-1:0] sx;
		logic [POS_W-1:0] sy;
		logic [PIX_W-1:0] src;
		logic [PIX_W-1:0] dst;
	} pos_t;

endpackage

FILE: hw/rtl/cwab_cfg.sv
// Configuration register file for the blit; clamps sizes to 1..MAX_DIM.
// Depends on cwab_pkg.
module cwab_cfg #(
	parameter int MAX_DIM = cwab_pkg::MAX_DIM_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cwab_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cwab_pkg::CFG_DATA_W-1:0]       cfg_data,
	output cwab_pkg::cfg_t                        cfg
);

	localparam int DW = cwab_pkg::CFG_DATA_W;
	localparam logic [DW:0] MAX_V = (DW+1)'(MAX_DIM);

	logic signed [DW-1:0] window_x_q, window_y_q;
	logic [DW-1:0] window_width_q, window_height_q, screen_width_q, screen_height_q;
	logic [cwab_pkg::ALPHA_W-1:0] blend_alpha_q;
	logic window_visible_q;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
		logic [DW-1:0] r;
		if (v == '0)
			r = DW'(1);
		else if ({1'b0, v} > MAX_V)
			r = MAX_V[DW-1:0];
		else
			r = v;
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_x_q       <= '0;
			window_y_q       <= '0;
			window_width_q   <= DW'(1);
			window_height_q  <= DW'(1);
			blend_alpha_q    <= cwab_pkg::ALPHA_OPAQUE;
			window_visible_q <= 1'b1;
			screen_width_q   <= DW'(1024);
			screen_height_q  <= DW'(768);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cwab_pkg::reg_idx_t'(cfg_index))
				cwab_pkg::REG_WINDOW_X:      window_x_q       <= $signed(cfg_data);
				cwab_pkg::REG_WINDOW_Y:      window_y_q       <= $signed(cfg_data);
				cwab_pkg::REG_WINDOW_WIDTH:  window_width_q   <= cfg_data;
				cwab_pkg::REG_WINDOW_HEIGHT: window_height_q  <= cfg_data;
				cwab_pkg::REG_BLEND_ALPHA:   blend_alpha_q    <= cfg_data[cwab_pkg::ALPHA_W-1:0];
				cwab_pkg::REG_WINDOW_VIS:    window_visible_q <= cfg_data[0];
				cwab_pkg::REG_SCREEN_WIDTH:  screen_width_q   <= cfg_data;
				cwab_pkg::REG_SCREEN_HEIGHT: screen_height_q  <= cfg_data;
			endcase
		end
	end

	always_comb begin
		cfg.window_x       = window_x_q;
		cfg.window_y       = window_y_q;
		cfg.window_width   = clamp_dim(window_width_q);
		cfg.window_height  = clamp_dim(window_height_q);
		cfg.blend_alpha    = blend_alpha_q;
		cfg.window_visible = window_visible_q;
		cfg.screen_width   = clamp_dim(screen_width_q);
		cfg.screen_height  = clamp_dim(screen_height_q);
	end

endmodule

FILE: hw/rtl/cwab_pos.sv
// Input stage: column/row counters, screen position and clipping, stage 1 register.
// Depends on cwab_pkg.
module cwab_pos #(
	parameter int MAX_DIM = cwab_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cwab_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cwab_pkg::PIX_W-1:0]    source_pixel,
	input  logic [cwab_pkg::PIX_W-1:0]    backdrop_pixel,
	input  logic                          adv,
	output logic                          valid_s1,
	output cwab_pkg::pos_t                pos_s1
);

	localparam int DW = cwab_pkg::CFG_DATA_W;
	localparam int CW = $clog2(MAX_DIM);
	localparam int MW = (CW > DW) ? CW : DW;
	localparam int LW = MW + 1;
	localparam int PW = MW + 2;

	logic [CW-1:0] column_q, row_q;
	logic last_col, last_row, on_screen, accept;
	logic signed [PW-1:0] sx, sy;
	cwab_pkg::pos_t pos_d;

	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	always_comb begin
		last_col  = (LW'(column_q) + LW'(1)) >= LW'(cfg.window_width);
		last_row  = (LW'(row_q) + LW'(1)) >= LW'(cfg.window_height);
		sx        = PW'($signed(cfg.window_x)) + $signed(PW'(column_q));
		sy        = PW'($signed(cfg.window_y)) + $signed(PW'(row_q));
		on_screen = !sx[PW-1] && !sy[PW-1] &&
		            ($unsigned(sx) < PW'(cfg.screen_width)) &&
		            ($unsigned(sy) < PW'(cfg.screen_height));
		pos_d.we   = on_screen && cfg.window_visible;
		pos_d.last = last_col && last_row;
		pos_d.sx   = sx[cwab_pkg::POS_W-1:0];
		pos_d.sy   = sy[cwab_pkg::POS_W-1:0];
		pos_d.src  = source_pixel;
		pos_d.dst  = backdrop_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (accept) begin
				if (last_col) begin
					column_q <= '0;
					row_q    <= last_row ? '0 : row_q + CW'(1);
				end else begin
					column_q <= column_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pos_s1 <= pos_d;
	end

endmodule

FILE: hw/rtl/cwab_blend.sv
// Output stage: framebuffer address, per-channel alpha blend, result register.
// Depends on cwab_pkg.
module cwab_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cwab_pkg::cfg_t                cfg,
	input  logic                          valid_s1,
	input  cwab_pkg::pos_t                pos_s1,
	output logic                          adv,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          write_enable,
	output logic [cwab_pkg::ADDR_W-1:0]   write_address,
	output logic [cwab_pkg::PIX_W-1:0]    blended_pixel,
	output logic                          last_pixel
);

	localparam int AW = 2 * cwab_pkg::POS_W;
	localparam int AL = cwab_pkg::ALPHA_W;

	logic [AW-1:0] addr_full;
	logic [cwab_pkg::PIX_W-1:0] mix;

	function automatic logic [AL-1:0] mix_ch(input logic [AL-1:0] s, input logic [AL-1:0] d,
	                                        input logic [AL-1:0] a);
		logic [2*AL:0] acc;
		logic [AL-1:0] ia;
		ia  = cwab_pkg::ALPHA_OPAQUE - a;
		acc = ((2*AL+1)'(s) * (2*AL+1)'(a)) + ((2*AL+1)'(d) * (2*AL+1)'(ia));
		return acc[2*AL-1:AL];
	endfunction

	always_comb begin
		addr_full = AW'(pos_s1.sy) * AW'(cfg.screen_width) + AW'(pos_s1.sx);
		priority if (cfg.blend_alpha == cwab_pkg::ALPHA_OPAQUE)
			mix = pos_s1.src;
		else if (cfg.blend_alpha == cwab_pkg::ALPHA_CLEAR)
			mix = pos_s1.dst;
		else
			mix = {mix_ch(pos_s1.src[23:16], pos_s1.dst[23:16], cfg.blend_alpha),
			       mix_ch(pos_s1.src[15:8],  pos_s1.dst[15:8],  cfg.blend_alpha),
			       mix_ch(pos_s1.src[7:0],   pos_s1.dst[7:0],   cfg.blend_alpha)};
	end

	assign adv = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (!out_valid || out_ready)
			out_valid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			write_enable  <= pos_s1.we;
			write_address <= pos_s1.we ? addr_full[cwab_pkg::ADDR_W-1:0] : '0;
			blended_pixel <= pos_s1.we ? mix : '0;
			last_pixel    <= pos_s1.last;
		end
	end

endmodule

FILE: hw/rtl/clipped_window_alpha_blit_top.sv
// Throughput: one pixel per cycle while out_ready is high, through the two registers of the pipeline
// (position/clip register, then address multiply and blend into the result register).
// Ready falls only when both stages are full and out_ready is low.
// Reset: counters at column 0 row 0, registers at their defaults, pipeline empty.
// Top level; depends on cwab_pkg, cwab_cfg, cwab_pos, cwab_blend.
module clipped_window_alpha_blit_top #(
	parameter int MAX_DIM = cwab_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cwab_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cwab_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cwab_pkg::PIX_W-1:0]        source_pixel,
	input  logic [cwab_pkg::PIX_W-1:0]        backdrop_pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              write_enable,
	output logic [cwab_pkg::ADDR_W-1:0]       write_address,
	output logic [cwab_pkg::PIX_W-1:0]        blended_pixel,
	output logic                              last_pixel
);

	cwab_pkg::cfg_t cfg;
	cwab_pkg::pos_t pos_s1;
	logic valid_s1, adv;

	cwab_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cwab_pos #(.MAX_DIM(MAX_DIM)) u_pos (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.source_pixel   (source_pixel),
		.backdrop_pixel (backdrop_pixel),
		.adv            (adv),
		.valid_s1       (valid_s1),
		.pos_s1         (pos_s1)
	);

	cwab_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.pos_s1        (pos_s1),
		.adv           (adv),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.blended_pixel (blended_pixel),
		.last_pixel    (last_pixel)
	);

endmodule
